// ===== rtl/palup_pkg.sv =====
// palup_pkg: shared types, widths and codes of the palette upscaler
// used by palup_geom, palup_front, palup_fifo, palup_back and the top; depends on nothing
`default_nettype none

package palup_pkg;

	localparam int SOURCE_WIDTH_DEF  = 256;
	localparam int SOURCE_HEIGHT_DEF = 240;
	localparam int MAX_SCALE_DEF     = 8;
	localparam int PALETTE_DEPTH_DEF = 64;

	localparam int SLOT_W   = 6;
	localparam int BGR_W    = 32;
	localparam int COORD_W  = 8;
	localparam int CINDEX_W = 8;
	localparam int ADDR_W   = 22;
	localparam int SWIDTH_W = 12;
	localparam int SHEIGHT_W = 11;
	localparam int SCALE_W  = 4;
	localparam int OFF_W    = 11;
	localparam int POS_W    = 12;
	localparam int PROD_W   = 2 * POS_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [SLOT_W-1:0] INDEX_MASK = 6'h3F;
	localparam logic [BGR_W-1:0]  BGR_NONE   = 32'h0000_0000;

	localparam logic [SWIDTH_W-1:0]  SCREEN_WIDTH_RST  = 12'd256;
	localparam logic [SHEIGHT_W-1:0] SCREEN_HEIGHT_RST = 11'd240;

	typedef enum logic {
		REQ_PALETTE = 1'b0,
		REQ_PIXEL   = 1'b1
	} req_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SPAN,
		ST_BASE,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		logic                req_type;
		logic [SLOT_W-1:0]   palette_slot;
		logic [BGR_W-1:0]    palette_value;
		logic [COORD_W-1:0]  pixel_x;
		logic [COORD_W-1:0]  pixel_y;
		logic [CINDEX_W-1:0] color_index;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] write_address;
		logic [BGR_W-1:0]  pixel_bgr;
		logic              last_of_block;
	} result_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [BGR_W-1:0]   pixel_bgr;
	} job_t;

	typedef struct packed {
		logic [SCALE_W-1:0]  scale;
		logic [OFF_W-1:0]    offset_col;
		logic [OFF_W-1:0]    offset_row;
		logic [SWIDTH_W-1:0] screen_width;
	} geom_t;

endpackage

`default_nettype wire

// ===== rtl/palup_stream_if.sv =====
// palup_stream_if: valid/ready channel carrying one payload per transaction
// payload type is set where the channel is instantiated
`default_nettype none

interface palup_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/palup_geom.sv =====
// palup_geom: screen size registers and derived scale and centring offsets
// depends on palup_pkg
`default_nettype none

module palup_geom
	import palup_pkg::*;
#(
	parameter int SOURCE_WIDTH  = SOURCE_WIDTH_DEF,
	parameter int SOURCE_HEIGHT = SOURCE_HEIGHT_DEF,
	parameter int MAX_SCALE     = MAX_SCALE_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output geom_t                      geom
);

	localparam int SRC_MAX  = (SOURCE_WIDTH > SOURCE_HEIGHT) ? SOURCE_WIDTH : SOURCE_HEIGHT;
	localparam int SPAN_BW  = $clog2(MAX_SCALE * SRC_MAX + 1);
	localparam int CMP_W    = (SPAN_BW > SWIDTH_W) ? SPAN_BW : SWIDTH_W;

	logic [SWIDTH_W-1:0]  width_q;
	logic [SHEIGHT_W-1:0] height_q;
	geom_t                geom_q;

	logic [SCALE_W-1:0] fit_w;
	logic [SCALE_W-1:0] fit_h;
	logic [SCALE_W-1:0] scale;
	logic [CMP_W-1:0]   span_w;
	logic [CMP_W-1:0]   span_h;
	logic [CMP_W-1:0]   wide_w;
	logic [CMP_W-1:0]   wide_h;
	logic [CMP_W-1:0]   diff_w;
	logic [CMP_W-1:0]   diff_h;
	geom_t              geom_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SCREEN_WIDTH_RST;
			height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: height_q <= cfg_data[SHEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// largest multiple (up to MAX_SCALE) of the source size that fits, per axis
	always_comb begin
		wide_w = CMP_W'(width_q);
		wide_h = CMP_W'(height_q);
		fit_w  = '0;
		fit_h  = '0;
		for (int k = 1; k <= MAX_SCALE; k++) begin
			if (wide_w >= CMP_W'(k * SOURCE_WIDTH))
				fit_w = SCALE_W'(k);
			if (wide_h >= CMP_W'(k * SOURCE_HEIGHT))
				fit_h = SCALE_W'(k);
		end
		scale = (fit_w < fit_h) ? fit_w : fit_h;
		if (scale == '0)
			scale = SCALE_W'(1);
		span_w = CMP_W'(SOURCE_WIDTH) * CMP_W'(scale);
		span_h = CMP_W'(SOURCE_HEIGHT) * CMP_W'(scale);
		diff_w = wide_w - span_w;
		diff_h = wide_h - span_h;
		geom_d.scale        = scale;
		geom_d.offset_col   = (wide_w > span_w) ? OFF_W'(diff_w >> 1) : '0;
		geom_d.offset_row   = (wide_h > span_h) ? OFF_W'(diff_h >> 1) : '0;
		geom_d.screen_width = width_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.scale        <= SCALE_W'(1);
			geom_q.offset_col   <= '0;
			geom_q.offset_row   <= '0;
			geom_q.screen_width <= SCREEN_WIDTH_RST;
		end else begin
			geom_q <= geom_d;
		end
	end

	assign geom = geom_q;

endmodule

`default_nettype wire

// ===== rtl/palup_front.sv =====
// palup_front: accepts transactions, keeps the palette memory, looks up pixel colors
// depends on palup_pkg and palup_stream_if
`default_nettype none

module palup_front
	import palup_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	palup_stream_if.sink   item,
	output logic           push_valid,
	output job_t           push_data,
	input  wire logic      push_full
);

	localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	logic [BGR_W-1:0] pal_mem [PALETTE_DEPTH];
	logic [BGR_W-1:0] rd_q;

	logic               valid_s1;
	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] y_s1;
	logic               oob_s1;

	logic              accept;
	logic              is_pixel;
	logic [SLOT_W-1:0] rd_idx;
	logic              wr_en;
	logic              push;

	assign item.ready = !valid_s1 || !push_full;
	assign accept     = item.valid && item.ready;
	assign is_pixel   = (item.payload.req_type == REQ_PIXEL);
	assign rd_idx     = item.payload.color_index[SLOT_W-1:0] & INDEX_MASK;
	assign wr_en      = accept && !is_pixel && (int'(item.payload.palette_slot) < PALETTE_DEPTH);
	assign push       = valid_s1 && !push_full;

	always_ff @(posedge clk) begin
		if (wr_en)
			pal_mem[PAL_AW'(item.payload.palette_slot)] <= item.payload.palette_value;
	end

	always_ff @(posedge clk) begin
		if (accept && is_pixel) begin
			rd_q   <= pal_mem[PAL_AW'(rd_idx)];
			x_s1   <= item.payload.pixel_x;
			y_s1   <= item.payload.pixel_y;
			oob_s1 <= (int'(rd_idx) >= PALETTE_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && is_pixel) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	assign push_valid          = valid_s1;
	assign push_data.pixel_x   = x_s1;
	assign push_data.pixel_y   = y_s1;
	assign push_data.pixel_bgr = oob_s1 ? BGR_NONE : rd_q;

endmodule

`default_nettype wire

// ===== rtl/palup_fifo.sv =====
// palup_fifo: short queue of looked-up pixels between front and back
// depends on palup_pkg
`default_nettype none

module palup_fifo
	import palup_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	input  wire job_t push_data,
	output logic      push_full,
	output logic      pop_valid,
	output job_t      pop_data,
	input  wire logic pop_ready
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic push;
	logic pop;

	assign push_full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];
	assign push      = push_valid && !push_full;
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== rtl/palup_back.sv =====
// palup_back: expands one queued pixel into scale x scale screen writes
// depends on palup_pkg and palup_stream_if
`default_nettype none

module palup_back
	import palup_pkg::*;
#(
	parameter int MAX_SCALE = MAX_SCALE_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire geom_t      geom,
	input  wire logic       pop_valid,
	input  wire job_t       pop_data,
	output logic            pop_ready,
	palup_stream_if.source  result
);

	back_state_t state_q;
	back_state_t state_d;

	geom_t              g_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [BGR_W-1:0]   bgr_q;
	logic [POS_W-1:0]   row0_q;
	logic [POS_W-1:0]   col0_q;
	logic [ADDR_W-1:0]  row_base_q;
	logic [SCALE_W-1:0] sx_q;
	logic [SCALE_W-1:0] sy_q;

	result_t res_q;
	logic    res_valid_q;

	logic               emit_go;
	logic               row_end;
	logic               last;
	logic [SCALE_W-1:0] s_top;

	assign s_top   = g_q.scale - SCALE_W'(1);
	assign row_end = (sx_q == s_top);
	assign last    = row_end && (sy_q == s_top);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (pop_valid) state_d = ST_SPAN;
			ST_SPAN: state_d = ST_BASE;
			ST_BASE: state_d = ST_EMIT;
			ST_EMIT: if (emit_go && last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = 1'b0;
		emit_go   = 1'b0;
		unique case (state_q)
			ST_IDLE: pop_ready = 1'b1;
			ST_EMIT: emit_go = !res_valid_q || result.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_go)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			g_q   <= geom;
			x_q   <= pop_data.pixel_x;
			y_q   <= pop_data.pixel_y;
			bgr_q <= pop_data.pixel_bgr;
		end
		if (state_q == ST_SPAN) begin
			row0_q <= POS_W'(g_q.offset_row) + POS_W'(y_q) * POS_W'(g_q.scale);
			col0_q <= POS_W'(g_q.offset_col) + POS_W'(x_q) * POS_W'(g_q.scale);
		end
		if (state_q == ST_BASE) begin
			row_base_q <= ADDR_W'(PROD_W'(row0_q) * PROD_W'(g_q.screen_width)
				+ PROD_W'(col0_q));
			sx_q <= '0;
			sy_q <= '0;
		end
		if (emit_go) begin
			res_q.write_address <= row_base_q + ADDR_W'(sx_q);
			res_q.pixel_bgr     <= bgr_q;
			res_q.last_of_block <= last;
			if (row_end) begin
				sx_q       <= '0;
				sy_q       <= sy_q + SCALE_W'(1);
				row_base_q <= row_base_q + ADDR_W'(g_q.screen_width);
			end else begin
				sx_q <= sx_q + SCALE_W'(1);
			end
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (g_q.scale != '0) && (g_q.scale <= SCALE_W'(MAX_SCALE)))
		else $error("scale out of range while busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (sx_q < g_q.scale) && (sy_q < g_q.scale))
		else $error("block counters past scale");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && last) |=> (state_q == ST_IDLE) && res_valid_q && res_q.last_of_block)
		else $error("final write did not end the block");

endmodule

`default_nettype wire

// ===== rtl/palette_integer_upscaler_top.sv =====
// palette_integer_upscaler_top: palette nearest-neighbor upscaler, front/queue/back
// path: a pixel passes the front lookup register, the queue, back states SPAN and BASE, then the output register
// back end: takes no new pixel until its scale*scale writes are done, one write per cycle while result is ready
// a palette write gives no result; a config write passes the size register and then the geom register
// reset: async active low, screen 256x240, scale 1, offsets 0; palette undefined until written
`default_nettype none

module palette_integer_upscaler_top
	import palup_pkg::*;
#(
	parameter int SOURCE_WIDTH  = SOURCE_WIDTH_DEF,
	parameter int SOURCE_HEIGHT = SOURCE_HEIGHT_DEF,
	parameter int MAX_SCALE     = MAX_SCALE_DEF,
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	palup_stream_if.sink               item,
	palup_stream_if.source             result
);

	geom_t geom;
	logic  push_valid;
	job_t  push_data;
	logic  push_full;
	logic  pop_valid;
	job_t  pop_data;
	logic  pop_ready;

	palup_geom #(
		.SOURCE_WIDTH  (SOURCE_WIDTH),
		.SOURCE_HEIGHT (SOURCE_HEIGHT),
		.MAX_SCALE     (MAX_SCALE)
	) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	palup_front #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_full  (push_full)
	);

	palup_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_full  (push_full),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	palup_back #(
		.MAX_SCALE (MAX_SCALE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.result    (result)
	);

endmodule

`default_nettype wire
